@@ src/i8583_pkg.sv @@
// Shared types, constants and functions of the ISO 8583 message deframer.
// Holds the field format ROM, the BCD length prefix decoder and byte size helpers.
// Depends on nothing; used by i8583_next_field and iso8583_message_deframer.
package i8583_pkg;

    localparam int BITMAP_BITS  = 64;
    localparam int HEADER_BYTES = 10;
    localparam int TYPE_BYTES   = 2;
    localparam int FIELD_W      = 7;
    localparam int UNITS_W      = 10;

    // Parser phase, one-hot.
    typedef enum logic [4:0] {
        PH_HEADER  = 5'b00001,
        PH_SEEK    = 5'b00010,
        PH_PREFIX  = 5'b00100,
        PH_DATA    = 5'b01000,
        PH_TRAILER = 5'b10000
    } phase_t;

    // Tag carried with every output word.
    typedef enum logic [2:0] {
        KIND_TYPE    = 3'd0,
        KIND_BITMAP  = 3'd1,
        KIND_PREFIX  = 3'd2,
        KIND_DATA    = 3'd3,
        KIND_TRAILER = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_HDR_SHORT = 2'd1,
        ST_TRUNCATED = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        FMT_FIX = 2'd0,
        FMT_LL  = 2'd1,
        FMT_LLL = 2'd2
    } fmt_t;

    typedef struct packed {
        logic [UNITS_W-1:0] max_units;
        fmt_t               fmt;
        logic               bcd_packed;
    } field_fmt_t;

    // Field format ROM, indexed by field number.
    function automatic field_fmt_t field_rom(input logic [FIELD_W-1:0] f);
        field_fmt_t r;
        case (f)
            7'd0:    r = '{10'd4,   FMT_FIX, 1'b1};
            7'd1:    r = '{10'd16,  FMT_FIX, 1'b1};
            7'd2:    r = '{10'd19,  FMT_LL,  1'b1};
            7'd3:    r = '{10'd6,   FMT_FIX, 1'b1};
            7'd4:    r = '{10'd12,  FMT_FIX, 1'b1};
            7'd5:    r = '{10'd12,  FMT_FIX, 1'b1};
            7'd6:    r = '{10'd12,  FMT_FIX, 1'b1};
            7'd7:    r = '{10'd10,  FMT_FIX, 1'b1};
            7'd8:    r = '{10'd0,   FMT_FIX, 1'b1};
            7'd9:    r = '{10'd8,   FMT_FIX, 1'b1};
            7'd10:   r = '{10'd8,   FMT_FIX, 1'b1};
            7'd11:   r = '{10'd6,   FMT_FIX, 1'b1};
            7'd12:   r = '{10'd6,   FMT_FIX, 1'b1};
            7'd13:   r = '{10'd4,   FMT_FIX, 1'b1};
            7'd14:   r = '{10'd4,   FMT_FIX, 1'b1};
            7'd15:   r = '{10'd4,   FMT_FIX, 1'b1};
            7'd16:   r = '{10'd4,   FMT_FIX, 1'b1};
            7'd17:   r = '{10'd0,   FMT_FIX, 1'b1};
            7'd18:   r = '{10'd4,   FMT_FIX, 1'b1};
            7'd19:   r = '{10'd3,   FMT_FIX, 1'b1};
            7'd20:   r = '{10'd0,   FMT_FIX, 1'b1};
            7'd21:   r = '{10'd0,   FMT_FIX, 1'b1};
            7'd22:   r = '{10'd3,   FMT_FIX, 1'b1};
            7'd23:   r = '{10'd3,   FMT_FIX, 1'b1};
            7'd24:   r = '{10'd0,   FMT_FIX, 1'b1};
            7'd25:   r = '{10'd2,   FMT_FIX, 1'b1};
            7'd26:   r = '{10'd2,   FMT_FIX, 1'b1};
            7'd27:   r = '{10'd0,   FMT_LL,  1'b1};
            7'd28:   r = '{10'd9,   FMT_FIX, 1'b0};
            7'd29:   r = '{10'd0,   FMT_LL,  1'b1};
            7'd30:   r = '{10'd0,   FMT_LL,  1'b1};
            7'd31:   r = '{10'd0,   FMT_LL,  1'b1};
            7'd32:   r = '{10'd11,  FMT_LL,  1'b1};
            7'd33:   r = '{10'd11,  FMT_LL,  1'b1};
            7'd34:   r = '{10'd0,   FMT_LLL, 1'b1};
            7'd35:   r = '{10'd37,  FMT_LL,  1'b1};
            7'd36:   r = '{10'd104, FMT_LLL, 1'b1};
            7'd37:   r = '{10'd12,  FMT_FIX, 1'b0};
            7'd38:   r = '{10'd6,   FMT_FIX, 1'b0};
            7'd39:   r = '{10'd2,   FMT_FIX, 1'b0};
            7'd40:   r = '{10'd0,   FMT_LL,  1'b1};
            7'd41:   r = '{10'd8,   FMT_FIX, 1'b0};
            7'd42:   r = '{10'd15,  FMT_FIX, 1'b0};
            7'd43:   r = '{10'd40,  FMT_FIX, 1'b0};
            7'd44:   r = '{10'd25,  FMT_LL,  1'b0};
            7'd45:   r = '{10'd79,  FMT_LL,  1'b1};
            7'd46:   r = '{10'd0,   FMT_LLL, 1'b1};
            7'd47:   r = '{10'd0,   FMT_LLL, 1'b1};
            7'd48:   r = '{10'd322, FMT_LLL, 1'b1};
            7'd49:   r = '{10'd3,   FMT_FIX, 1'b0};
            7'd50:   r = '{10'd3,   FMT_FIX, 1'b0};
            7'd51:   r = '{10'd3,   FMT_FIX, 1'b0};
            7'd52:   r = '{10'd8,   FMT_FIX, 1'b0};
            7'd53:   r = '{10'd16,  FMT_FIX, 1'b1};
            7'd54:   r = '{10'd40,  FMT_LLL, 1'b0};
            7'd55:   r = '{10'd255, FMT_LLL, 1'b0};
            7'd56:   r = '{10'd0,   FMT_LLL, 1'b1};
            7'd57:   r = '{10'd100, FMT_LLL, 1'b0};
            7'd58:   r = '{10'd100, FMT_LLL, 1'b0};
            7'd59:   r = '{10'd600, FMT_LLL, 1'b0};
            7'd60:   r = '{10'd17,  FMT_LLL, 1'b1};
            7'd61:   r = '{10'd29,  FMT_LLL, 1'b1};
            7'd62:   r = '{10'd512, FMT_LLL, 1'b0};
            7'd63:   r = '{10'd163, FMT_LLL, 1'b0};
            7'd64:   r = '{10'd8,   FMT_FIX, 1'b0};
            default: r = '{10'd0,   FMT_FIX, 1'b0};
        endcase
        return r;
    endfunction

    // A field occupies message bytes unless it is fixed with zero length.
    function automatic logic field_needs_bytes(input logic [FIELD_W-1:0] f);
        field_fmt_t e;
        e = field_rom(f);
        return (e.fmt != FMT_FIX) || (e.max_units != '0);
    endfunction

    // Packed numeric fields hold two digits per byte.
    function automatic logic [UNITS_W-1:0] bytes_for(input field_fmt_t e,
                                                     input logic [UNITS_W-1:0] units);
        logic [UNITS_W:0] sum;
        sum = {1'b0, units} + {{UNITS_W{1'b0}}, 1'b1};
        return e.bcd_packed ? sum[UNITS_W:1] : units;
    endfunction

    // Decimal decode of four nibbles, most significant first, stopping at
    // the first nibble that is not a decimal digit.
    function automatic logic [13:0] decode_prefix(input logic [15:0] raw);
        logic [13:0] v;
        logic        stop;
        logic [3:0]  nib;
        v    = '0;
        stop = 1'b0;
        for (int i = 3; i >= 0; i--) begin
            nib = raw[4*i +: 4];
            if (!stop) begin
                if (nib > 4'd9) begin
                    stop = 1'b1;
                end
                else begin
                    v = 14'((v << 3) + (v << 1) + {10'd0, nib});
                end
            end
        end
        return v;
    endfunction

endpackage

@@ src/iso8583_message_deframer.sv @@
// ISO 8583 message deframer: one byte in, one tagged byte out per word.
// Uses i8583_pkg and two instances of i8583_next_field.
//
// The block takes a packed ISO 8583 message one byte per word and returns
// one output word per input word, tagging the byte as message type, primary
// bitmap, length prefix, field data or trailer, with its field number, a
// field-end flag and the decoded length of the field. Bytes 0-1 are the
// message type, bytes 2-9 the primary bitmap (byte 2 holds fields 1 to 8,
// MSB first). Present fields 1 to 64 are then walked in order using the
// built-in format ROM; LL and LLL prefixes are BCD, decoded up to the first
// non-decimal nibble and capped at the field maximum. Field 1 passes as 8
// data bytes. On the word flagged message_last the status reports a short
// header or a truncated field and the parser returns to its reset state.
// The next-field search, prefix decode and state update sit between the state
// registers and the output register, so a new byte is accepted each cycle while
// the output does not stall, and its result is registered for the following cycle. The output
// register stalls the input only while it holds a word not yet taken.
module iso8583_message_deframer
    import i8583_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [7:0]   byte_value,
    input  logic         message_last,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [7:0]   data_byte,
    output logic [6:0]   field_number,
    output logic [2:0]   byte_kind,
    output logic         field_end,
    output logic [9:0]   field_digits,
    output logic         message_end,
    output logic [1:0]   parse_status
);

    // Parser state.
    phase_t                   phase_reg, phase_next;
    logic [3:0]               header_count_reg, header_count_next;
    logic [BITMAP_BITS-1:0]   bitmap_reg, bitmap_next;
    logic [FIELD_W-1:0]       field_reg, field_next;
    logic [7:0]               prefix_raw_reg, prefix_raw_next;
    logic [UNITS_W-1:0]       digits_reg, digits_next;
    logic [1:0]               prefix_left_reg, prefix_left_next;
    logic [UNITS_W-1:0]       data_left_reg, data_left_next;

    // Output register.
    logic                     out_valid_reg;
    logic [7:0]               data_byte_reg;
    logic [FIELD_W-1:0]       field_number_reg;
    kind_t                    kind_reg;
    logic                     field_end_reg;
    logic [UNITS_W-1:0]       field_digits_reg;
    logic                     message_end_reg;
    status_t                  status_reg;

    // Result of the current byte.
    kind_t                    r_kind;
    logic [FIELD_W-1:0]       r_field;
    logic                     r_end;
    logic [UNITS_W-1:0]       r_digits;
    status_t                  r_status;

    logic                     in_fire;
    logic [FIELD_W-1:0]       seek_field, after_field;
    logic                     seek_found, after_found;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // Next field to open from the current position.
    i8583_next_field u_seek (
        .bitmap (bitmap_reg),
        .after  (field_reg),
        .field  (seek_field),
        .found  (seek_found)
    );

    // Whether a further field is still owed after this byte.
    i8583_next_field u_owed (
        .bitmap (bitmap_next),
        .after  (field_next),
        .field  (after_field),
        .found  (after_found)
    );

    // Per-byte state step and result tagging.
    always_comb
    begin
        field_fmt_t         ent;
        logic [15:0]        raw16;
        logic [13:0]        len;
        logic [UNITS_W-1:0] capped;
        phase_next        = phase_reg;
        header_count_next = header_count_reg;
        bitmap_next       = bitmap_reg;
        field_next        = field_reg;
        prefix_raw_next   = prefix_raw_reg;
        digits_next       = digits_reg;
        prefix_left_next  = prefix_left_reg;
        data_left_next    = data_left_reg;
        r_kind            = KIND_TRAILER;
        r_field           = '0;
        r_end             = 1'b0;
        r_digits          = '0;
        ent               = '0;
        raw16             = '0;
        len               = '0;
        capped            = '0;
        if (phase_reg == PH_HEADER) begin
            r_kind = (header_count_reg < 4'(TYPE_BYTES)) ? KIND_TYPE : KIND_BITMAP;
            if (header_count_reg >= 4'(TYPE_BYTES)) begin
                bitmap_next = {bitmap_reg[BITMAP_BITS-9:0], byte_value};
            end
            r_end = (header_count_reg == 4'(TYPE_BYTES - 1)) ||
                    (header_count_reg == 4'(HEADER_BYTES - 1));
            header_count_next = header_count_reg + 4'd1;
            if (header_count_next >= 4'(HEADER_BYTES)) begin
                phase_next = PH_SEEK;
                field_next = '0;
            end
        end
        else begin
            // Open the next present field.
            if (phase_reg == PH_SEEK) begin
                if (!seek_found) begin
                    phase_next = PH_TRAILER;
                    field_next = '0;
                end
                else begin
                    field_next = seek_field;
                    ent        = field_rom(seek_field);
                    if (ent.fmt == FMT_FIX) begin
                        phase_next     = PH_DATA;
                        digits_next    = ent.max_units;
                        data_left_next = bytes_for(ent, ent.max_units);
                    end
                    else begin
                        phase_next       = PH_PREFIX;
                        prefix_left_next = (ent.fmt == FMT_LL) ? 2'd1 : 2'd2;
                        digits_next      = '0;
                    end
                end
            end
            ent = field_rom(field_next);
            // Length prefix bytes.
            if (phase_next == PH_PREFIX) begin
                r_kind = KIND_PREFIX;
                if (prefix_left_next == 2'd2) begin
                    prefix_raw_next  = byte_value;
                    prefix_left_next = 2'd1;
                end
                else begin
                    raw16  = (ent.fmt == FMT_LL) ? {byte_value, 8'hff}
                                                 : {prefix_raw_next, byte_value};
                    len    = decode_prefix(raw16);
                    capped = ({4'd0, ent.max_units} <= len) ? ent.max_units
                                                            : len[UNITS_W-1:0];
                    digits_next      = capped;
                    prefix_left_next = 2'd0;
                    data_left_next   = bytes_for(ent, capped);
                    r_digits         = capped;
                    if (data_left_next == '0) begin
                        r_end      = 1'b1;
                        phase_next = PH_SEEK;
                    end
                    else begin
                        phase_next = PH_DATA;
                    end
                end
                r_field = field_next;
            end
            // Field data bytes.
            else if (phase_next == PH_DATA) begin
                r_kind   = KIND_DATA;
                r_digits = digits_next;
                r_field  = field_next;
                if (data_left_next != '0) begin
                    data_left_next = data_left_next - UNITS_W'(1);
                end
                if (data_left_next == '0) begin
                    r_end      = 1'b1;
                    phase_next = PH_SEEK;
                end
            end
        end
    end

    // Status is reported only on the last byte of a message.
    always_comb
    begin
        r_status = ST_OK;
        if (message_last) begin
            if (phase_next == PH_HEADER) begin
                r_status = ST_HDR_SHORT;
            end
            else if (phase_next == PH_PREFIX || phase_next == PH_DATA) begin
                r_status = ST_TRUNCATED;
            end
            else if (phase_next == PH_SEEK && after_found) begin
                r_status = ST_TRUNCATED;
            end
        end
    end

    // State registers; the last byte of a message returns them to reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg        <= PH_HEADER;
            header_count_reg <= '0;
            bitmap_reg       <= '0;
            field_reg        <= '0;
            prefix_raw_reg   <= '0;
            digits_reg       <= '0;
            prefix_left_reg  <= '0;
            data_left_reg    <= '0;
        end
        else if (in_fire) begin
            if (message_last) begin
                phase_reg        <= PH_HEADER;
                header_count_reg <= '0;
                bitmap_reg       <= '0;
                field_reg        <= '0;
                prefix_raw_reg   <= '0;
                digits_reg       <= '0;
                prefix_left_reg  <= '0;
                data_left_reg    <= '0;
            end
            else begin
                phase_reg        <= phase_next;
                header_count_reg <= header_count_next;
                bitmap_reg       <= bitmap_next;
                field_reg        <= field_next;
                prefix_raw_reg   <= prefix_raw_next;
                digits_reg       <= digits_next;
                prefix_left_reg  <= prefix_left_next;
                data_left_reg    <= data_left_next;
            end
        end
    end

    // Output word valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready) begin
            out_valid_reg <= in_valid;
        end
    end

    // Output word payload.
    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            data_byte_reg    <= byte_value;
            field_number_reg <= r_field;
            kind_reg         <= r_kind;
            field_end_reg    <= r_end;
            field_digits_reg <= r_digits;
            message_end_reg  <= message_last;
            status_reg       <= r_status;
        end
    end

    assign out_valid    = out_valid_reg;
    assign data_byte    = data_byte_reg;
    assign field_number = field_number_reg;
    assign byte_kind    = kind_reg;
    assign field_end    = field_end_reg;
    assign field_digits = field_digits_reg;
    assign message_end  = message_end_reg;
    assign parse_status = status_reg;

`ifndef SYNTHESIS
    // The last byte of a message leaves the parser at the start of a header.
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && message_last |=> phase_reg == PH_HEADER &&
                                    header_count_reg == '0 && bitmap_reg == '0)
        else $error("parser did not restart after the last byte");

    // A status other than ok appears only on the last byte of a message.
    a_status_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !message_end |-> parse_status == ST_OK)
        else $error("status reported before the end of a message");

    // Trailer bytes belong to no field.
    a_trailer_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_kind == KIND_TRAILER |->
            field_number == '0 && !field_end && field_digits == '0)
        else $error("trailer byte tagged with field information");

    // Header bytes are never tagged with a field number.
    a_header_field: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (byte_kind == KIND_TYPE || byte_kind == KIND_BITMAP) |->
            field_number == '0 && field_digits == '0)
        else $error("header byte tagged with a field number");
`endif

endmodule

@@ src/i8583_next_field.sv @@
// Next present field finder: lowest-numbered field above a given field that is
// set in the bitmap and whose format needs message bytes.
// Depends on i8583_pkg for the format ROM and widths.
module i8583_next_field
    import i8583_pkg::*;
(
    input  logic [BITMAP_BITS-1:0] bitmap,
    input  logic [FIELD_W-1:0]     after,
    output logic [FIELD_W-1:0]     field,
    output logic                   found
);

    // Priority search from the top down so the lowest candidate wins.
    always_comb
    begin
        logic [FIELD_W-1:0] f;
        field = '0;
        found = 1'b0;
        for (int i = BITMAP_BITS - 1; i >= 0; i--) begin
            f = FIELD_W'(i + 1);
            if (bitmap[BITMAP_BITS-1-i] && field_needs_bytes(f) && (f > after)) begin
                field = f;
                found = 1'b1;
            end
        end
    end

endmodule

@@ bench/deframer_tag_checker.sv @@
// Field format table shared by the deframer bench, and the checker that predicts and compares
// every tagged output word. Depends on i8583_pkg for the format and phase types.
package deframer_fields_pkg;
    import i8583_pkg::*;

    // Maximum length in units of each field, indexed by field number.
    localparam int unsigned UNIT_CAP [0:64] = '{
        4, 16, 19, 6, 12, 12, 12, 10,
        0, 8, 8, 6, 6, 4, 4, 4,
        4, 0, 4, 3, 0, 0, 3, 3,
        0, 2, 2, 0, 9, 0, 0, 0,
        11, 11, 0, 37, 104, 12, 6, 2,
        0, 8, 15, 40, 25, 79, 0, 0,
        322, 3, 3, 3, 8, 16, 40, 255,
        0, 100, 100, 600, 17, 29, 512, 163,
        8
    };

    // Length encoding of each field.
    localparam fmt_t FIELD_FMT [0:64] = '{
        FMT_FIX, FMT_FIX, FMT_LL,  FMT_FIX, FMT_FIX, FMT_FIX, FMT_FIX, FMT_FIX,
        FMT_FIX, FMT_FIX, FMT_FIX, FMT_FIX, FMT_FIX, FMT_FIX, FMT_FIX, FMT_FIX,
        FMT_FIX, FMT_FIX, FMT_FIX, FMT_FIX, FMT_FIX, FMT_FIX, FMT_FIX, FMT_FIX,
        FMT_FIX, FMT_FIX, FMT_FIX, FMT_LL,  FMT_FIX, FMT_LL,  FMT_LL,  FMT_LL,
        FMT_LL,  FMT_LL,  FMT_LLL, FMT_LL,  FMT_LLL, FMT_FIX, FMT_FIX, FMT_FIX,
        FMT_LL,  FMT_FIX, FMT_FIX, FMT_FIX, FMT_LL,  FMT_LL,  FMT_LLL, FMT_LLL,
        FMT_LLL, FMT_FIX, FMT_FIX, FMT_FIX, FMT_FIX, FMT_FIX, FMT_LLL, FMT_LLL,
        FMT_LLL, FMT_LLL, FMT_LLL, FMT_LLL, FMT_LLL, FMT_LLL, FMT_LLL, FMT_LLL,
        FMT_FIX
    };

    // Numeric fields carry two digits per byte; bit f belongs to field f.
    localparam logic [0:64] BCD_PACKED =
        65'b1111_1111_1111_1111_1111_1111_1111_0_1111_1111_000_1_0000_1111_0000_1_00_1_000_11_000;

    // Fixed fields of zero length take no bytes at all.
    function automatic bit occupies(input int f);
        return (FIELD_FMT[f] != FMT_FIX) || (UNIT_CAP[f] != 0);
    endfunction

    function automatic int unsigned field_bytes(input int f, input int unsigned units);
        return BCD_PACKED[f] ? (units + 1) / 2 : units;
    endfunction

    // Decimal value of the low nibbles, most significant first; reading stops at the
    // first nibble that is not a decimal digit.
    function automatic int unsigned bcd_value(input logic [15:0] raw, input int nibbles);
        int unsigned v;
        int          i;
        logic [3:0]  nib;
        bit          stop;
        v    = 0;
        stop = 1'b0;
        for (i = nibbles - 1; i >= 0; i--)
        begin
            nib = raw[4*i +: 4];
            if (nib > 4'd9)
                stop = 1'b1;
            if (!stop)
                v = v * 10 + nib;
        end
        return v;
    endfunction

endpackage

module deframer_tag_checker
    import i8583_pkg::*;
    import deframer_fields_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] byte_value,
    input  logic       message_last,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] data_byte,
    input  logic [6:0] field_number,
    input  logic [2:0] byte_kind,
    input  logic       field_end,
    input  logic [9:0] field_digits,
    input  logic       message_end,
    input  logic [1:0] parse_status,
    output int         error_count,
    output int         words_waiting
);

    typedef struct {
        logic [7:0] data;
        logic [6:0] field;
        kind_t      kind;
        logic       fend;
        logic [9:0] digits;
        logic       mend;
        status_t    status;
    } tag_word_t;

    tag_word_t   tags_due [$];
    int          mismatches = 0;
    int          due_count  = 0;
    int          words_seen = 0;

    // Parser state as predicted from the accepted input words.
    phase_t      phase;
    int unsigned hdr_count;
    logic [63:0] bitmap;
    int unsigned cur_field;
    int unsigned units;
    int unsigned prefix_left;
    int unsigned data_left;

    assign error_count   = mismatches;
    assign words_waiting = due_count;

    task automatic flag_mismatch(input string what, input int got, input int want);
        if (mismatches < 100)
            $display("word %0d: %s is %0d, expected %0d", words_seen, what, got, want);
        mismatches++;
    endtask

    task automatic clear_state();
        phase       = PH_HEADER;
        hdr_count   = 0;
        bitmap      = '0;
        cur_field   = 0;
        units       = 0;
        prefix_left = 0;
        data_left   = 0;
    endtask

    // Next present field after the given one that occupies bytes; 0 when none is left.
    function automatic int unsigned next_present(input int unsigned after);
        int f;
        for (f = after + 1; f <= 64; f++)
        begin
            if (bitmap[64-f] && occupies(f))
                return f;
        end
        return 0;
    endfunction

    // Tag one accepted byte and advance the predicted parser state.
    task automatic tag_next_byte(input logic [7:0] b, input logic last, output tag_word_t w);
        int unsigned f;
        int unsigned len;
        w.data   = b;
        w.field  = '0;
        w.kind   = KIND_TRAILER;
        w.fend   = 1'b0;
        w.digits = '0;
        w.mend   = last;
        w.status = ST_OK;
        if (phase == PH_HEADER)
        begin
            w.kind = (hdr_count < TYPE_BYTES) ? KIND_TYPE : KIND_BITMAP;
            if (hdr_count >= TYPE_BYTES)
                bitmap = {bitmap[55:0], b};
            w.fend = (hdr_count == 1) || (hdr_count == HEADER_BYTES - 1);
            hdr_count++;
            if (hdr_count >= HEADER_BYTES)
            begin
                phase     = PH_SEEK;
                cur_field = 0;
            end
            if (last)
            begin
                if (phase == PH_HEADER)
                    w.status = ST_HDR_SHORT;
                else if (next_present(0) != 0)
                    w.status = ST_TRUNCATED;
            end
        end
        else
        begin
            // Pick the next present field when the previous one has ended.
            if (phase == PH_SEEK)
            begin
                f = next_present(cur_field);
                if (f == 0)
                begin
                    phase     = PH_TRAILER;
                    cur_field = 0;
                end
                else
                begin
                    cur_field = f;
                    if (FIELD_FMT[f] == FMT_FIX)
                    begin
                        phase     = PH_DATA;
                        units     = UNIT_CAP[f];
                        data_left = field_bytes(f, UNIT_CAP[f]);
                    end
                    else
                    begin
                        phase       = PH_PREFIX;
                        prefix_left = (FIELD_FMT[f] == FMT_LL) ? 1 : 2;
                        units       = 0;
                    end
                end
            end
            if (phase == PH_PREFIX)
            begin
                w.kind = KIND_PREFIX;
                if (prefix_left >= 2)
                begin
                    // First byte of a three-digit prefix is held until the second arrives.
                    units       = b;
                    prefix_left = 1;
                end
                else
                begin
                    if (FIELD_FMT[cur_field] == FMT_LL)
                        len = bcd_value({8'h00, b}, 2);
                    else
                        len = bcd_value({units[7:0], b}, 4);
                    if (UNIT_CAP[cur_field] <= len)
                        len = UNIT_CAP[cur_field];
                    units       = len;
                    prefix_left = 0;
                    data_left   = field_bytes(cur_field, len);
                    w.digits    = 10'(len);
                    if (data_left == 0)
                    begin
                        w.fend = 1'b1;
                        phase  = PH_SEEK;
                    end
                    else
                        phase = PH_DATA;
                end
                w.field = 7'(cur_field);
            end
            else if (phase == PH_DATA)
            begin
                w.kind   = KIND_DATA;
                w.digits = 10'(units);
                w.field  = 7'(cur_field);
                if (data_left > 0)
                    data_left--;
                if (data_left == 0)
                begin
                    w.fend = 1'b1;
                    phase  = PH_SEEK;
                end
            end
            if (last)
            begin
                if (phase == PH_PREFIX || phase == PH_DATA)
                    w.status = ST_TRUNCATED;
                else if (phase == PH_SEEK && next_present(cur_field) != 0)
                    w.status = ST_TRUNCATED;
            end
        end
        if (last)
            clear_state();
    endtask

    // Compare each accepted output word with the oldest prediction, then predict the new input.
    always @(posedge clk or negedge rst_n)
    begin
        tag_word_t want;
        tag_word_t fresh;
        if (!rst_n)
        begin
            clear_state();
            tags_due.delete();
            due_count = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (tags_due.size() == 0)
                    flag_mismatch("word with nothing expected, data_byte", data_byte, 0);
                else
                begin
                    want = tags_due.pop_front();
                    if (data_byte !== want.data)
                        flag_mismatch("data_byte", data_byte, want.data);
                    if (field_number !== want.field)
                        flag_mismatch("field_number", field_number, want.field);
                    if (byte_kind !== want.kind)
                        flag_mismatch("byte_kind", byte_kind, want.kind);
                    if (field_end !== want.fend)
                        flag_mismatch("field_end", field_end, want.fend);
                    if (field_digits !== want.digits)
                        flag_mismatch("field_digits", field_digits, want.digits);
                    if (message_end !== want.mend)
                        flag_mismatch("message_end", message_end, want.mend);
                    if (parse_status !== want.status)
                        flag_mismatch("parse_status", parse_status, want.status);
                end
                words_seen++;
            end
            if (in_valid && in_ready)
            begin
                tag_next_byte(byte_value, message_last, fresh);
                tags_due.push_back(fresh);
            end
            due_count = tags_due.size();
        end
    end

endmodule

@@ bench/iso8583_message_deframer_tb.sv @@
// Top of the deframer bench: clock, reset, message stimulus and output back-pressure.
// Depends on i8583_pkg, deframer_fields_pkg and deframer_tag_checker, which does all checking.
module iso8583_message_deframer_tb;
    import i8583_pkg::*;
    import deframer_fields_pkg::*;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_ready;
    logic [7:0] byte_value   = 8'h00;
    logic       message_last = 1'b0;
    logic       out_valid;
    logic       out_ready    = 1'b0;
    logic [7:0] data_byte;
    logic [6:0] field_number;
    logic [2:0] byte_kind;
    logic       field_end;
    logic [9:0] field_digits;
    logic       message_end;
    logic [1:0] parse_status;

    int         fail_count;
    int         words_waiting;
    int         items_sent = 0;
    bit         calm_tail  = 1'b0;
    int         gap_pct    = 0;
    int         stall_pct  = 0;
    int         stall_left = 0;
    int         ready_ticks = 0;
    logic [7:0] msg [$];

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    iso8583_message_deframer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .byte_value   (byte_value),
        .message_last (message_last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .data_byte    (data_byte),
        .field_number (field_number),
        .byte_kind    (byte_kind),
        .field_end    (field_end),
        .field_digits (field_digits),
        .message_end  (message_end),
        .parse_status (parse_status)
    );

    deframer_tag_checker tag_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .byte_value    (byte_value),
        .message_last  (message_last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .data_byte     (data_byte),
        .field_number  (field_number),
        .byte_kind     (byte_kind),
        .field_end     (field_end),
        .field_digits  (field_digits),
        .message_end   (message_end),
        .parse_status  (parse_status),
        .error_count   (fail_count),
        .words_waiting (words_waiting)
    );

    function automatic int pick_pressure();
        case ($urandom_range(0, 3))
            0, 1:    return 0;
            2:       return 10;
            default: return 35;
        endcase
    endfunction

    // Receiver back-pressure: stall bursts of random length, the burst rate redrawn by
    // pick_pressure, and none once the tail of the run is reached.
    always @(posedge clk)
    begin
        if (ready_ticks % 200 == 0)
            stall_pct = pick_pressure();
        ready_ticks++;
        if (stall_left != 0)
            stall_left--;
        else if (!calm_tail && $urandom_range(0, 99) < stall_pct)
        begin
            out_ready  <= 1'b0;
            stall_left = $urandom_range(1, 14) - 1;
        end
        else
            out_ready <= 1'b1;
    end

    // Offer one byte, possibly after an idle burst, and wait until it is taken.
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (!calm_tail && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        byte_value   <= b;
        message_last <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        if (items_sent >= 620)
            calm_tail = 1'b1;
    endtask

    task automatic send_message();
        int i;
        gap_pct = pick_pressure();
        for (i = 0; i < msg.size(); i++)
            send_byte(msg[i], i == msg.size() - 1);
    endtask

    function automatic logic [15:0] to_bcd(input int unsigned v);
        return {4'(v / 1000 % 10), 4'(v / 100 % 10), 4'(v / 10 % 10), 4'(v % 10)};
    endfunction

    // Build one message: mostly well formed with random content, some cut short
    // anywhere, and a few made of pure noise.
    task automatic build_message();
        logic [63:0] bitmap;
        logic [15:0] raw;
        int          shape;
        int          density;
        int          f;
        int          i;
        int          r;
        int unsigned cap;
        int unsigned v;
        int unsigned nbytes;
        int          keep;
        msg.delete();
        shape = $urandom_range(0, 99);
        if (shape < 6)
        begin
            repeat ($urandom_range(1, 24)) msg.push_back(8'($urandom));
            return;
        end
        r = $urandom_range(0, 49);
        if (r == 0)
            density = 100;
        else if (r < 5)
            density = 0;
        else
            density = $urandom_range(3, 30);
        for (f = 1; f <= 64; f++)
            bitmap[64-f] = $urandom_range(0, 99) < density;
        msg.push_back(8'($urandom));
        msg.push_back(8'($urandom));
        for (i = 0; i < 8; i++)
            msg.push_back(bitmap[63 - 8*i -: 8]);
        for (f = 1; f <= 64; f++)
        begin
            if (bitmap[64-f] && occupies(f))
            begin
                cap = UNIT_CAP[f];
                if (FIELD_FMT[f] == FMT_FIX)
                    nbytes = field_bytes(f, cap);
                else
                begin
                    // Claimed length: mostly short, sometimes the maximum or beyond it,
                    // and sometimes a prefix with non-decimal nibbles.
                    r = $urandom_range(0, 99);
                    if (r < 70)
                        v = $urandom_range(0, (cap < 9) ? cap : 9);
                    else if (r < 82)
                        v = $urandom_range(0, (cap < 60) ? cap : 60);
                    else if (r < 86)
                        v = (cap <= 104 || $urandom_range(0, 19) == 0) ? cap : 60;
                    else if (r < 92 && cap <= 104)
                        v = $urandom_range(cap, (FIELD_FMT[f] == FMT_LL) ? 99 : 9999);
                    else
                        v = 0;
                    raw = (r >= 92) ? 16'($urandom) : to_bcd(v);
                    if (FIELD_FMT[f] == FMT_LLL)
                        msg.push_back(raw[15:8]);
                    msg.push_back(raw[7:0]);
                    if (FIELD_FMT[f] == FMT_LL)
                        v = bcd_value({8'h00, raw[7:0]}, 2);
                    else
                        v = bcd_value(raw, 4);
                    if (v > cap)
                        v = cap;
                    nbytes = field_bytes(f, v);
                end
                repeat (nbytes) msg.push_back(8'($urandom));
            end
        end
        if ($urandom_range(0, 99) < 30)
            repeat ($urandom_range(1, 3)) msg.push_back(8'($urandom));
        // Broken message: the final byte lands anywhere, header included.
        if (shape < 16)
        begin
            keep = $urandom_range(1, msg.size());
            while (msg.size() > keep)
                void'(msg.pop_back());
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Header cut short after the message type.
        msg = '{8'hFF, 8'h00};
        send_message();
        // Fields 2, 8, 34, 63 and 64: a prefix with a non-decimal nibble, a zero-length
        // fixed field, a zero-maximum prefix capped to nothing, an empty three-digit
        // prefix, and a message that ends while field 64 is still owed.
        msg = '{8'h00, 8'hFF, 8'h41, 8'h00, 8'h00, 8'h00, 8'h40, 8'h00, 8'h00, 8'h03,
                8'h1A, 8'hA5, 8'h09, 8'h99, 8'h00, 8'h0F};
        send_message();

        while (items_sent < 700)
        begin
            build_message();
            send_message();
        end
        in_valid     <= 1'b0;
        message_last <= 1'b0;

        while (words_waiting != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0 && words_waiting == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

@@ files.f @@
src/i8583_pkg.sv
src/i8583_next_field.sv
src/iso8583_message_deframer.sv
bench/deframer_tag_checker.sv
bench/iso8583_message_deframer_tb.sv
